### hw/rtl/u8opt_pkg.sv
// ----------------------------------------------------------------------------
// u8opt_pkg
// Shared constants and types for the u8 outer-product tile accumulator:
// tile size, field widths, command codes and the structs that travel along
// the column chain.
// ----------------------------------------------------------------------------
package u8opt_pkg;

  localparam int TILE_DIM  = 16;   // tile rows and columns, 2 .. 16
  localparam int MAX_DIM   = 16;   // columns carried on the result ports
  localparam int LANE_W    = 4;
  localparam int WORD_W    = 32;
  localparam int ACC_W     = 32;
  localparam int OUT_W     = 64;
  localparam int NUM_PAIRS = MAX_DIM / 2;
  localparam int BYTE_W    = 8;
  localparam int NUM_BYTES = WORD_W / BYTE_W;
  localparam int PROD_W    = 2 * BYTE_W;
  localparam int DOT_W     = PROD_W + 2;
  localparam int ROW_W     = (TILE_DIM > 1) ? $clog2(TILE_DIM) : 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // one A lane walking down the chain, tagged with its tile row
  typedef struct packed {
    logic              vld;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] a_word;
  } chain_t;

  // row read and clear, broadcast to every cell during a drain
  typedef struct packed {
    logic             clr;
    logic [ROW_W-1:0] row;
  } drn_ctl_t;

endpackage

### hw/rtl/u8opt_cell.sv
// ----------------------------------------------------------------------------
// u8opt_cell
// One tile column: holds its B lane word and the column's accumulators,
// forms the 4-byte dot product with each passing A lane and hands the
// A lane on to the next column through a register.
// ----------------------------------------------------------------------------
module u8opt_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u8opt_pkg::chain_t             chain_in,
  output u8opt_pkg::chain_t             chain_out,
  input  u8opt_pkg::drn_ctl_t           drn,
  input  logic                          b_we,
  input  logic [u8opt_pkg::WORD_W-1:0]  b_word,
  output logic [u8opt_pkg::ACC_W-1:0]   rd_data
);
  import u8opt_pkg::*;

  chain_t              chain_r;
  logic [WORD_W-1:0]   b_r;
  logic                dot_vld_r;
  logic [ROW_W-1:0]    dot_row_r;
  logic [DOT_W-1:0]    dot_r;
  logic [DOT_W-1:0]    dot_nxt;
  logic [PROD_W-1:0]   prod [NUM_BYTES];
  logic [ACC_W-1:0]    acc_r [TILE_DIM];
  logic [TILE_DIM-1:0] acc_vld_r;
  logic [ACC_W-1:0]    acc_cur;
  logic [ACC_W-1:0]    acc_nxt;

  always_comb begin
    dot_nxt = '0;
    for (int g = 0; g < NUM_BYTES; g++) begin
      prod[g] = {{BYTE_W{1'b0}}, chain_in.a_word[BYTE_W*g +: BYTE_W]} *
                {{BYTE_W{1'b0}}, b_r[BYTE_W*g +: BYTE_W]};
      dot_nxt = dot_nxt + {2'b00, prod[g]};
    end
  end

  // an entry without its valid bit reads as zero
  assign acc_cur = acc_vld_r[dot_row_r] ? acc_r[dot_row_r] : '0;
  assign acc_nxt = acc_cur + {{(ACC_W-DOT_W){1'b0}}, dot_r};
  assign rd_data = acc_vld_r[drn.row] ? acc_r[drn.row] : '0;
  assign chain_out = chain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r.vld <= 1'b0;
      dot_vld_r   <= 1'b0;
      acc_vld_r   <= '0;
    end else begin
      chain_r   <= chain_in;
      dot_vld_r <= chain_in.vld;
      if (drn.clr) begin
        acc_vld_r[drn.row] <= 1'b0;
      end else if (dot_vld_r) begin
        acc_vld_r[dot_row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    dot_row_r <= chain_in.row;
    dot_r     <= dot_nxt;
    if (b_we) begin
      b_r <= b_word;
    end
    if (dot_vld_r && !drn.clr) begin
      acc_r[dot_row_r] <= acc_nxt;
    end
  end

endmodule

### hw/rtl/u8_outer_product_tile_mac.sv
// ----------------------------------------------------------------------------
// u8_outer_product_tile_mac
// 16x16 tile of 32-bit sums fed by u8 outer products, one k-group of four
// bytes per lane, drained row by row.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken when start is high and busy is low. in_command selects a
//   lane load or a drain. A load writes A into the lane buffer and B into
//   the column cell of in_lane; a lane at or above the tile size is dropped.
//   Loads of lanes other than the last leave busy low. The load of the last
//   lane starts the group update: A lanes enter the column chain one per
//   cycle and travel one column per cycle, and busy stays high after that
//   load until the last column has added in the last lane.
//   A drain keeps busy high until the last row is read. Row r appears on
//   the out_ ports, marked by out_strobe, registered from the drain state,
//   in row order; each row is shown for one cycle and out_last_row flags
//   the final one. Rows are cleared as they are read. The receiver cannot
//   stall the drain. Reset clears every accumulator (per-entry valid bits);
//   the lane buffers hold nothing defined until written.
// ----------------------------------------------------------------------------
module u8_outer_product_tile_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [u8opt_pkg::LANE_W-1:0]  in_lane,
  input  logic [u8opt_pkg::WORD_W-1:0]  in_a_word,
  input  logic [u8opt_pkg::WORD_W-1:0]  in_b_word,
  output logic                          out_strobe,
  output logic [u8opt_pkg::LANE_W-1:0]  out_row_index,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_0_1,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_2_3,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_4_5,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_6_7,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_8_9,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_10_11,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_12_13,
  output logic [u8opt_pkg::OUT_W-1:0]   out_cols_14_15,
  output logic                          out_last_row
);
  import u8opt_pkg::*;

  localparam int UPD_LAST = 2 * TILE_DIM;
  localparam int CNT_W    = $clog2(UPD_LAST + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_UPD, ST_DRAIN} state_t;

  state_t             st_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ROW_W-1:0]   drn_row_r;
  chain_t             feed_r;
  chain_t             feed_nxt;
  logic [WORD_W-1:0]  a_buf_r [TILE_DIM];
  logic               out_strobe_r;
  logic [LANE_W-1:0]  out_row_r;
  logic               out_last_r;
  logic [OUT_W-1:0]   out_pair_r [NUM_PAIRS];
  logic [OUT_W-1:0]   out_pair_nxt [NUM_PAIRS];

  logic               accept;
  logic               lane_ok;
  logic               load_we;
  logic [ROW_W-1:0]   lane_row;
  logic               drn_last;
  drn_ctl_t           drn;
  chain_t             chain_w [TILE_DIM+1];
  logic [ACC_W-1:0]   col_sum [MAX_DIM];

  assign busy     = (st_r != ST_IDLE);
  assign accept   = start && !busy;
  assign lane_ok  = ({1'b0, in_lane} < (LANE_W+1)'(TILE_DIM));
  assign lane_row = in_lane[ROW_W-1:0];
  assign load_we  = accept && (in_command == CMD_LOAD) && lane_ok;
  assign drn_last = (drn_row_r == ROW_W'(TILE_DIM - 1));

  assign drn.clr = (st_r == ST_DRAIN);
  assign drn.row = drn_row_r;

  // lane feeder for the group update
  always_comb begin
    feed_nxt.vld    = (st_r == ST_UPD) && (cnt_r < CNT_W'(TILE_DIM));
    feed_nxt.row    = cnt_r[ROW_W-1:0];
    feed_nxt.a_word = a_buf_r[cnt_r[ROW_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      a_buf_r[lane_row] <= in_a_word;
    end
  end

  assign chain_w[0] = feed_r;

  for (genvar j = 0; j < MAX_DIM; j++) begin : g_col
    if (j < TILE_DIM) begin : g_cell
      u8opt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .chain_in  (chain_w[j]),
        .chain_out (chain_w[j+1]),
        .drn       (drn),
        .b_we      (load_we && (lane_row == ROW_W'(j))),
        .b_word    (in_b_word),
        .rd_data   (col_sum[j])
      );
    end else begin : g_pad
      assign col_sum[j] = '0;
    end
  end

  always_comb begin
    for (int p = 0; p < NUM_PAIRS; p++) begin
      out_pair_nxt[p] = {col_sum[2*p+1], col_sum[2*p]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      cnt_r        <= '0;
      drn_row_r    <= '0;
      feed_r.vld   <= 1'b0;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      feed_r       <= feed_nxt;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (accept && (in_command == CMD_DRAIN)) begin
            st_r      <= ST_DRAIN;
            drn_row_r <= '0;
          end else if (load_we && (lane_row == ROW_W'(TILE_DIM - 1))) begin
            st_r  <= ST_UPD;
            cnt_r <= '0;
          end
        end
        ST_UPD: begin
          cnt_r <= cnt_r + 1'b1;
          // last column has taken its last lane
          if (cnt_r == CNT_W'(UPD_LAST)) begin
            st_r <= ST_IDLE;
          end
        end
        ST_DRAIN: begin
          out_strobe_r <= 1'b1;
          out_last_r   <= drn_last;
          out_row_r    <= LANE_W'(drn_row_r);
          out_pair_r   <= out_pair_nxt;
          drn_row_r    <= drn_row_r + 1'b1;
          if (drn_last) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_row_index  = out_row_r;
  assign out_last_row   = out_last_r;
  assign out_cols_0_1   = out_pair_r[0];
  assign out_cols_2_3   = out_pair_r[1];
  assign out_cols_4_5   = out_pair_r[2];
  assign out_cols_6_7   = out_pair_r[3];
  assign out_cols_8_9   = out_pair_r[4];
  assign out_cols_10_11 = out_pair_r[5];
  assign out_cols_12_13 = out_pair_r[6];
  assign out_cols_14_15 = out_pair_r[7];

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(st_r == ST_DRAIN))
    else $error("row word without a drain cycle");

  a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_last_row) |=> out_strobe)
    else $error("drain rows not back to back");

  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DRAIN && drn_last) |=> (st_r == ST_IDLE && out_last_row))
    else $error("drain did not end on the last row");

  a_chain_tail: assert property (@(posedge clk) disable iff (!rst_n)
    chain_w[TILE_DIM].vld |-> (st_r == ST_UPD))
    else $error("lane still in the chain after the update ended");

endmodule
